// ===== rtl/core/ptnc_pkg.sv =====
package ptnc_pkg;

    // table depth default
    localparam int DEFAULT_CAPACITY = 64;

    // field widths
    localparam int COORD_W  = 16;
    localparam int RADIUS_W = 15;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int SQ_W     = 2 * DIFF_W;
    localparam int DIST_W   = SQ_W + 1;
    localparam int RSUM_W   = RADIUS_W + 1;
    localparam int R2_W     = 2 * RSUM_W;
    localparam int COUNT_W  = 7;

    localparam logic [RADIUS_W-1:0] ITEM_RADIUS_RESET = RADIUS_W'(16);

    // operation codes
    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_COLLIDE = 2'd1;
    localparam logic [1:0] OP_NEAREST = 2'd2;

endpackage

// ===== rtl/core/point_table_nearest_and_collide_core.sv =====
// channel  | handshake            | payload
// ---------+----------------------+-----------------------------------------------
// command  | start, busy          | operation, pos_x, pos_y, query_radius
// result   | done (one cycle)     | status, hit, found, near_x, near_y, point_count
// config   | cfg_we               | cfg_wdata (item_radius)
//
// insert, unused codes and an empty table: result in the cycle after the transaction
// nearest on n points: the single memory read port feeds the shared distance unit one
// point per cycle, then FETCH rereads the winner and LOAD registers the result
// collide miss: result when the last distance misses; a hit flushes the scan and
// answers once FETCH and LOAD have moved the last point into the hit slot
// reset clears the count and restores item_radius; the receiver cannot stall
module point_table_nearest_and_collide_core
    import ptnc_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                operation,
    input  logic signed [COORD_W-1:0] pos_x,
    input  logic signed [COORD_W-1:0] pos_y,
    input  logic [RADIUS_W-1:0]       query_radius,
    input  logic                      cfg_we,
    input  logic [RADIUS_W-1:0]       cfg_wdata,
    output logic                      done,
    output logic                      status,
    output logic                      hit,
    output logic                      found,
    output logic signed [COORD_W-1:0] near_x,
    output logic signed [COORD_W-1:0] near_y,
    output logic [COUNT_W-1:0]        point_count
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_LOAD
    } state_t;

    // point table, x in the upper half
    logic [2*COORD_W-1:0] mem [CAPACITY];
    logic [2*COORD_W-1:0] rd_data_reg;

    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [2*COORD_W-1:0] wr_data;

    // sequencer registers
    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      issuing_reg, issuing_next;
    logic [IDX_W-1:0]          issue_idx_reg, issue_idx_next;
    logic [IDX_W-1:0]          last_idx_reg, last_idx_next;
    logic [IDX_W-1:0]          best_idx_reg, best_idx_next;
    logic [DIST_W-1:0]         best_d_reg, best_d_next;
    logic                      seen_reg, seen_next;
    logic [1:0]                op_reg, op_next;
    logic signed [COORD_W-1:0] qx_reg, qx_next;
    logic signed [COORD_W-1:0] qy_reg, qy_next;
    logic [RSUM_W-1:0]         rs_reg, rs_next;
    logic [R2_W-1:0]           r2_reg;
    logic [RADIUS_W-1:0]       item_radius_reg;

    // registered result
    logic                      done_reg, done_next;
    logic                      status_reg, status_next;
    logic                      hit_reg, hit_next;
    logic                      found_reg, found_next;
    logic signed [COORD_W-1:0] near_x_reg, near_x_next;
    logic signed [COORD_W-1:0] near_y_reg, near_y_next;

    // read tag in step with rd_data_reg
    logic             rd_valid_reg;
    logic [IDX_W-1:0] rd_idx_reg;

    logic             d_valid;
    logic [IDX_W-1:0] d_idx;
    logic [DIST_W-1:0] d_dist;
    logic             d_last;
    logic             scan_hit;

    assign busy = (state_reg != S_IDLE);

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_radius_reg <= ITEM_RADIUS_RESET;
        end
        else if (cfg_we)
        begin
            item_radius_reg <= cfg_wdata;
        end
    end

    // squared collision radius, settles long before the first distance comes out
    always_ff @(posedge clk)
    begin
        r2_reg <= rs_reg * rs_reg;
    end

    // table memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // collide hit during the scan: later points still in flight are dropped
    assign scan_hit = (state_reg == S_SCAN) && d_valid && (op_reg == OP_COLLIDE)
                      && (d_dist < DIST_W'(r2_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= (state_reg == S_SCAN) && issuing_reg && !scan_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= issue_idx_reg;
    end

    // shared distance unit
    ptnc_dist #(
        .IDX_W (IDX_W)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .flush     (scan_hit),
        .in_valid  (rd_valid_reg),
        .in_idx    (rd_idx_reg),
        .qx        (qx_reg),
        .qy        (qy_reg),
        .px        (rd_data_reg[2*COORD_W-1:COORD_W]),
        .py        (rd_data_reg[COORD_W-1:0]),
        .out_valid (d_valid),
        .out_idx   (d_idx),
        .out_dist  (d_dist)
    );

    assign d_last = (d_idx == last_idx_reg);

    // memory port selection
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = issue_idx_reg;
        wr_en   = 1'b0;
        wr_addr = count_reg[IDX_W-1:0];
        wr_data = {pos_x, pos_y};
        unique case (state_reg)
            S_IDLE:
            begin
                wr_en = start && (operation == OP_INSERT) && (count_reg != CNT_FULL);
            end
            S_SCAN:
            begin
                rd_en = issuing_reg;
            end
            S_FETCH:
            begin
                // collide moves the last point, nearest rereads the winner
                rd_en   = 1'b1;
                rd_addr = (op_reg == OP_COLLIDE) ? last_idx_reg : best_idx_reg;
            end
            S_LOAD:
            begin
                wr_en   = (op_reg == OP_COLLIDE);
                wr_addr = best_idx_reg;
                wr_data = rd_data_reg;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        issuing_next   = issuing_reg;
        issue_idx_next = issue_idx_reg;
        last_idx_next  = last_idx_reg;
        best_idx_next  = best_idx_reg;
        best_d_next    = best_d_reg;
        seen_next      = seen_reg;
        op_next        = op_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        rs_next        = rs_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        hit_next       = hit_reg;
        found_next     = found_reg;
        near_x_next    = near_x_reg;
        near_y_next    = near_y_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next       = operation;
                    qx_next       = pos_x;
                    qy_next       = pos_y;
                    rs_next       = RSUM_W'(query_radius) + RSUM_W'(item_radius_reg);
                    status_next   = 1'b0;
                    hit_next      = 1'b0;
                    found_next    = 1'b0;
                    near_x_next   = '0;
                    near_y_next   = '0;
                    last_idx_next = IDX_W'(count_reg - CNT_W'(1));
                    case (operation) inside
                        OP_INSERT:
                        begin
                            done_next = 1'b1;
                            if (count_reg == CNT_FULL)
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_COLLIDE, OP_NEAREST:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next     = S_SCAN;
                                issuing_next   = 1'b1;
                                issue_idx_next = '0;
                                seen_next      = 1'b0;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // one read per cycle until the last stored point is issued or a collide hit stops it
                if (issuing_reg)
                begin
                    if (issue_idx_reg == last_idx_reg)
                    begin
                        issuing_next = 1'b0;
                    end
                    else
                    begin
                        issue_idx_next = issue_idx_reg + IDX_W'(1);
                    end
                end
                // results come back in index order; a collide hit flushes the rest
                if (d_valid)
                begin
                    if (op_reg == OP_COLLIDE)
                    begin
                        if (d_dist < DIST_W'(r2_reg))
                        begin
                            best_idx_next = d_idx;
                            issuing_next  = 1'b0;
                            state_next    = S_FETCH;
                        end
                        else if (d_last)
                        begin
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        // strict compare keeps the earliest index on ties
                        if (!seen_reg || (d_dist < best_d_reg))
                        begin
                            best_d_next   = d_dist;
                            best_idx_next = d_idx;
                            seen_next     = 1'b1;
                        end
                        if (d_last)
                        begin
                            state_next = S_FETCH;
                        end
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (op_reg == OP_COLLIDE)
                begin
                    hit_next   = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    found_next  = 1'b1;
                    near_x_next = rd_data_reg[2*COORD_W-1:COORD_W];
                    near_y_next = rd_data_reg[COORD_W-1:0];
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            issuing_reg   <= 1'b0;
            issue_idx_reg <= '0;
            last_idx_reg  <= '0;
            best_idx_reg  <= '0;
            best_d_reg    <= '0;
            seen_reg      <= 1'b0;
            op_reg        <= OP_INSERT;
            qx_reg        <= '0;
            qy_reg        <= '0;
            rs_reg        <= '0;
            done_reg      <= 1'b0;
            status_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            found_reg     <= 1'b0;
            near_x_reg    <= '0;
            near_y_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issuing_reg   <= issuing_next;
            issue_idx_reg <= issue_idx_next;
            last_idx_reg  <= last_idx_next;
            best_idx_reg  <= best_idx_next;
            best_d_reg    <= best_d_next;
            seen_reg      <= seen_next;
            op_reg        <= op_next;
            qx_reg        <= qx_next;
            qy_reg        <= qy_next;
            rs_reg        <= rs_next;
            done_reg      <= done_next;
            status_reg    <= status_next;
            hit_reg       <= hit_next;
            found_reg     <= found_next;
            near_x_reg    <= near_x_next;
            near_y_reg    <= near_y_next;
        end
    end

    // result ports; the count register already holds the post-transaction value
    assign done        = done_reg;
    assign status      = status_reg;
    assign hit         = hit_reg;
    assign found       = found_reg;
    assign near_x      = near_x_reg;
    assign near_y      = near_y_reg;
    assign point_count = COUNT_W'(count_reg);

endmodule

// ===== rtl/core/ptnc_dist.sv =====
module ptnc_dist
    import ptnc_pkg::*;
#(
    parameter int IDX_W = $clog2(DEFAULT_CAPACITY)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     flush,
    input  logic                     in_valid,
    input  logic [IDX_W-1:0]         in_idx,
    input  logic signed [COORD_W-1:0] qx,
    input  logic signed [COORD_W-1:0] qy,
    input  logic signed [COORD_W-1:0] px,
    input  logic signed [COORD_W-1:0] py,
    output logic                     out_valid,
    output logic [IDX_W-1:0]         out_idx,
    output logic [DIST_W-1:0]        out_dist
);

    logic                     s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [IDX_W-1:0]         s1_idx_reg, s2_idx_reg, s3_idx_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic signed [SQ_W-1:0]   sqx_reg, sqy_reg;
    logic [DIST_W-1:0]        sum_reg;

    // tag pipeline, flush drops everything in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid && !flush;
            s2_valid_reg <= s1_valid_reg && !flush;
            s3_valid_reg <= s2_valid_reg && !flush;
        end
    end

    // difference, square, sum
    always_ff @(posedge clk)
    begin
        s1_idx_reg <= in_idx;
        s2_idx_reg <= s1_idx_reg;
        s3_idx_reg <= s2_idx_reg;
        dx_reg     <= DIFF_W'(qx) - DIFF_W'(px);
        dy_reg     <= DIFF_W'(qy) - DIFF_W'(py);
        sqx_reg    <= dx_reg * dx_reg;
        sqy_reg    <= dy_reg * dy_reg;
        sum_reg    <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
    end

    assign out_valid = s3_valid_reg;
    assign out_idx   = s3_idx_reg;
    assign out_dist  = sum_reg;

endmodule
